// ===== hw/rtl/slt_pkg.sv =====
// slt_pkg: shared types and constants for the sync line tracker.
// No dependencies; used by sync_line_tracker.
package slt_pkg;

    localparam int POS_W  = 12;
    localparam int TS_W   = 32;
    localparam int VOFF_W = 10;
    localparam int HGT_W  = 7;
    localparam int LONG_W = 16;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 16;
    localparam int CFG_A_W = 2;

    // line position codes
    localparam logic [POS_W-1:0] POS_BLANK = 12'h000;
    localparam logic [POS_W-1:0] POS_FIRST = 12'h001;
    localparam logic [POS_W-1:0] POS_END   = 12'hFFF;
    // counting stops short of this line whatever the box says
    localparam logic [POS_W-1:0] POS_LIMIT = 12'h7FF;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_FRAME = 2'd1,
        ACT_ARMED = 2'd2,
        ACT_ENDED = 2'd3
    } t_action;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_V_OFFSET    = 2'd0,
        CFG_OSD_HEIGHT  = 2'd1,
        CFG_SYNC_POL    = 2'd2,
        CFG_LONG_SYNC   = 2'd3
    } t_cfg_index;

    typedef enum logic {
        EV_SYNC_EDGE = 1'b0,
        EV_VSYNC     = 1'b1
    } t_event_kind;

    localparam logic [VOFF_W-1:0] V_OFFSET_RST   = 10'd40;
    localparam logic [HGT_W-1:0]  OSD_HEIGHT_RST = 7'd0;
    localparam logic              SYNC_POL_RST   = 1'b0;
    localparam logic [LONG_W-1:0] LONG_SYNC_RST  = 16'd720;

endpackage

// ===== hw/rtl/sync_line_tracker.sv =====
// sync_line_tracker: composite sync separator and overlay line counter.
// Depends on slt_pkg.

// Each request is one sync edge (pin level plus a free-running 32-bit
// timestamp) or a vertical sync event, and yields exactly one result:
// nothing, frame started, line armed (with first-line flag and index in the
// box) or box ended. The line position and pulse start update and the
// result lands in an output register at the same edge, so one request per
// cycle is taken, also while a result is being drained; o_stall rises only
// when the output register is full and stalled. o_valid rises in the cycle
// after acceptance. Long sync pulses (wider than the long sync threshold)
// seen while blanked or after the box put the tracker in vertical blanking;
// the next short pulse starts a frame (or ends an empty box at once).
// Configuration writes take effect on the next request.
module sync_line_tracker #(
    parameter int MAX_OSD_LINES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_wr_en,
    input  logic [slt_pkg::CFG_A_W-1:0]  i_cfg_index,
    input  logic [slt_pkg::CFG_W-1:0]    i_cfg_data,
    // request side
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_event_kind,
    input  logic                         i_pin_level,
    input  logic [slt_pkg::TS_W-1:0]     i_timestamp,
    // result side
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_action,
    output logic                         o_first_line,
    output logic [slt_pkg::IDX_W-1:0]    o_box_line
);

    localparam int HMAX_W = $clog2(MAX_OSD_LINES + 1);
    localparam logic [HMAX_W-1:0] HMAX = HMAX_W'(MAX_OSD_LINES);

    // configuration registers
    logic [slt_pkg::VOFF_W-1:0] r_v_offset;
    logic [slt_pkg::HGT_W-1:0]  r_osd_height;
    logic                       r_sync_pol;
    logic [slt_pkg::LONG_W-1:0] r_long_sync;

    // tracker state
    logic [slt_pkg::POS_W-1:0]  r_line_pos, n_line_pos;
    logic [slt_pkg::TS_W-1:0]   r_pulse_start, n_pulse_start;

    // result register
    logic                       r_out_valid;
    slt_pkg::t_action           r_action, n_action;
    logic                       r_first, n_first;
    logic [slt_pkg::IDX_W-1:0]  r_box_line, n_box_line;

    logic                       in_accept;
    logic                       leading;
    logic [HMAX_W-1:0]          box_height;
    logic [slt_pkg::POS_W-1:0]  box_end;
    logic [slt_pkg::POS_W-1:0]  pos_inc;
    logic [slt_pkg::POS_W-1:0]  voff_ext;
    logic [slt_pkg::POS_W-1:0]  pos_rel;
    logic [slt_pkg::TS_W-1:0]   pulse_width;
    logic                       long_pulse;

    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_offset   <= slt_pkg::V_OFFSET_RST;
            r_osd_height <= slt_pkg::OSD_HEIGHT_RST;
            r_sync_pol   <= slt_pkg::SYNC_POL_RST;
            r_long_sync  <= slt_pkg::LONG_SYNC_RST;
        end else if (i_cfg_wr_en) begin
            unique case (slt_pkg::t_cfg_index'(i_cfg_index))
                slt_pkg::CFG_V_OFFSET:   r_v_offset   <= i_cfg_data[slt_pkg::VOFF_W-1:0];
                slt_pkg::CFG_OSD_HEIGHT: r_osd_height <= i_cfg_data[slt_pkg::HGT_W-1:0];
                slt_pkg::CFG_SYNC_POL:   r_sync_pol   <= i_cfg_data[0];
                slt_pkg::CFG_LONG_SYNC:  r_long_sync  <= i_cfg_data[slt_pkg::LONG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp height to the box limit
    always_comb begin
        if ({{(HMAX_W+slt_pkg::HGT_W){1'b0}}, r_osd_height} >
            {{slt_pkg::HGT_W{1'b0}}, {HMAX_W{1'b0}}, HMAX}) begin
            box_height = HMAX;
        end else begin
            box_height = HMAX_W'(r_osd_height);
        end
    end

    assign voff_ext    = slt_pkg::POS_W'(r_v_offset);
    assign box_end     = voff_ext + slt_pkg::POS_W'(box_height);
    assign pos_inc     = r_line_pos + slt_pkg::POS_W'(1);
    assign pos_rel     = pos_inc - voff_ext;
    assign leading     = (i_pin_level == r_sync_pol);
    assign pulse_width = i_timestamp - r_pulse_start;
    // negative width (bit 31 set) never counts as long
    assign long_pulse  = !pulse_width[slt_pkg::TS_W-1] &&
                         (pulse_width > slt_pkg::TS_W'(r_long_sync));

    always_comb begin
        n_line_pos    = r_line_pos;
        n_pulse_start = r_pulse_start;
        n_action      = slt_pkg::ACT_NONE;
        n_first       = 1'b0;
        n_box_line    = '0;
        if (i_event_kind == slt_pkg::EV_VSYNC) begin
            n_line_pos = slt_pkg::POS_BLANK;
        end else if (r_line_pos == slt_pkg::POS_BLANK || r_line_pos == slt_pkg::POS_END) begin
            if (leading) begin
                n_pulse_start = i_timestamp;
            end else if (long_pulse) begin
                n_line_pos = slt_pkg::POS_BLANK;
            end else if (r_line_pos == slt_pkg::POS_BLANK) begin
                if (box_height == '0) begin
                    n_line_pos = slt_pkg::POS_END;
                    n_action   = slt_pkg::ACT_ENDED;
                end else begin
                    n_line_pos = slt_pkg::POS_FIRST;
                    n_action   = slt_pkg::ACT_FRAME;
                end
            end
        end else if (leading) begin
            n_line_pos = pos_inc;
            if (pos_inc < voff_ext) begin
                n_action = slt_pkg::ACT_NONE;
            end else if (pos_inc >= box_end || pos_inc >= slt_pkg::POS_LIMIT) begin
                n_line_pos = slt_pkg::POS_END;
                n_action   = slt_pkg::ACT_ENDED;
            end else begin
                n_action   = slt_pkg::ACT_ARMED;
                n_first    = (pos_inc == voff_ext);
                n_box_line = pos_rel[slt_pkg::IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos    <= slt_pkg::POS_BLANK;
            r_pulse_start <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_line_pos    <= n_line_pos;
                r_pulse_start <= n_pulse_start;
                r_out_valid   <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action   <= n_action;
            r_first    <= n_first;
            r_box_line <= n_box_line;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_action     = r_action;
    assign o_first_line = r_first;
    assign o_box_line   = r_box_line;

    a_vsync_blanks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_event_kind == slt_pkg::EV_VSYNC |=> r_line_pos == slt_pkg::POS_BLANK)
        else $error("vsync did not force blanking");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_pos < slt_pkg::POS_LIMIT || r_line_pos == slt_pkg::POS_END)
        else $error("line position out of range");

    a_frame_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && n_action == slt_pkg::ACT_FRAME |=> r_line_pos == slt_pkg::POS_FIRST)
        else $error("frame start without first line position");

    a_idx_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_action != slt_pkg::ACT_ARMED |-> !r_first && r_box_line == '0)
        else $error("line index on a result that is not armed");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted request produced no result");

endmodule

// ===== tb/tb_sync_line_tracker.sv =====
// tb_sync_line_tracker: self-checking bench for the sync line tracker. A line
// tracking model predicts each result, which is checked in order under random
// request gaps and output stalls. Depends on slt_pkg and sync_line_tracker.
module tb_sync_line_tracker;

    localparam int MAX_LINES   = 64;
    localparam int ITEM_TARGET = 1250;
    localparam int DRAIN_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        slt_pkg::t_action          action;
        logic                      first_line;
        logic [slt_pkg::IDX_W-1:0] box_line;
    } t_line_report;

    typedef enum logic [1:0] {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } t_rx_mode;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic [slt_pkg::CFG_A_W-1:0] i_cfg_index;
    logic [slt_pkg::CFG_W-1:0]   i_cfg_data;
    logic                        i_valid;
    logic                        o_stall;
    logic                        i_event_kind;
    logic                        i_pin_level;
    logic [slt_pkg::TS_W-1:0]    i_timestamp;
    logic                        o_valid;
    logic                        i_stall;
    logic [1:0]                  o_action;
    logic                        o_first_line;
    logic [slt_pkg::IDX_W-1:0]   o_box_line;

    // tracker model: line position, pulse start and register copies
    logic [slt_pkg::POS_W-1:0]  trk_pos;
    logic [slt_pkg::TS_W-1:0]   trk_pulse_t0;
    logic [slt_pkg::VOFF_W-1:0] cfg_voff;
    logic [slt_pkg::HGT_W-1:0]  cfg_height;
    logic                       cfg_pol;
    logic [slt_pkg::LONG_W-1:0] cfg_long;

    t_line_report               pending_reports[$];
    int                         errors = 0;
    int                         n_sent = 0;
    int                         burst_left;
    bit                         offering = 1'b0;
    bit                         hold_req = 1'b0;
    logic [slt_pkg::TS_W-1:0]   now_ts;

    sync_line_tracker #(
        .MAX_OSD_LINES(MAX_LINES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_event_kind(i_event_kind),
        .i_pin_level (i_pin_level),
        .i_timestamp (i_timestamp),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_action    (o_action),
        .o_first_line(o_first_line),
        .o_box_line  (o_box_line)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [slt_pkg::HGT_W-1:0] clamped_height();
        return (cfg_height > MAX_LINES) ? slt_pkg::HGT_W'(MAX_LINES) : cfg_height;
    endfunction

    function automatic t_line_report track_sync(input slt_pkg::t_event_kind kind,
                                                input logic level,
                                                input logic [slt_pkg::TS_W-1:0] ts);
        t_line_report              rep;
        logic [slt_pkg::TS_W-1:0]  width;
        logic [slt_pkg::POS_W:0]   box_end;
        logic [slt_pkg::POS_W-1:0] offs;
        logic                      leading;
        rep.action     = slt_pkg::ACT_NONE;
        rep.first_line = 1'b0;
        rep.box_line   = '0;
        leading = (level == cfg_pol);
        if (kind == slt_pkg::EV_VSYNC) begin
            trk_pos = slt_pkg::POS_BLANK;
        end else if (trk_pos == slt_pkg::POS_BLANK || trk_pos == slt_pkg::POS_END) begin
            if (leading) begin
                trk_pulse_t0 = ts;
            end else begin
                width = ts - trk_pulse_t0;
                // wrapped width read as signed: negative is never long
                if (!width[slt_pkg::TS_W-1] && width > cfg_long) begin
                    trk_pos = slt_pkg::POS_BLANK;
                end else if (trk_pos == slt_pkg::POS_BLANK) begin
                    if (clamped_height() == 0) begin
                        trk_pos    = slt_pkg::POS_END;
                        rep.action = slt_pkg::ACT_ENDED;
                    end else begin
                        trk_pos    = slt_pkg::POS_FIRST;
                        rep.action = slt_pkg::ACT_FRAME;
                    end
                end
            end
        end else if (leading) begin
            box_end = cfg_voff + clamped_height();
            trk_pos = trk_pos + 1'b1;
            if (trk_pos >= cfg_voff) begin
                if (trk_pos >= box_end || trk_pos >= slt_pkg::POS_LIMIT) begin
                    trk_pos    = slt_pkg::POS_END;
                    rep.action = slt_pkg::ACT_ENDED;
                end else begin
                    offs           = trk_pos - cfg_voff;
                    rep.action     = slt_pkg::ACT_ARMED;
                    rep.first_line = (trk_pos == cfg_voff);
                    rep.box_line   = offs[slt_pkg::IDX_W-1:0];
                end
            end
        end
        return rep;
    endfunction

    // one request; valid stays high after acceptance unless a gap follows
    task automatic send_item(input slt_pkg::t_event_kind kind, input logic level,
                             input logic [slt_pkg::TS_W-1:0] ts);
        i_valid      <= 1'b1;
        i_event_kind <= kind;
        i_pin_level  <= level;
        i_timestamp  <= ts;
        offering = 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_reports.push_back(track_sync(kind, level, ts));
        n_sent++;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic lead_edge();
        send_item(slt_pkg::EV_SYNC_EDGE, cfg_pol, now_ts);
        now_ts = now_ts + $urandom_range(20, 4000);
    endtask

    task automatic sync_pulse(input logic [slt_pkg::TS_W-1:0] width);
        send_item(slt_pkg::EV_SYNC_EDGE, cfg_pol, now_ts);
        send_item(slt_pkg::EV_SYNC_EDGE, ~cfg_pol, now_ts + width);
        now_ts = now_ts + width + $urandom_range(20, 4000);
    endtask

    task automatic noise_item();
        send_item(slt_pkg::t_event_kind'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom());
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_reports.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_reports.size());
            errors++;
            pending_reports.delete();
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input slt_pkg::t_cfg_index idx,
                             input logic [slt_pkg::CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            slt_pkg::CFG_V_OFFSET:   cfg_voff   = data[slt_pkg::VOFF_W-1:0];
            slt_pkg::CFG_OSD_HEIGHT: cfg_height = data[slt_pkg::HGT_W-1:0];
            slt_pkg::CFG_SYNC_POL:   cfg_pol    = data[0];
            slt_pkg::CFG_LONG_SYNC:  cfg_long   = data[slt_pkg::LONG_W-1:0];
            default: ;
        endcase
    endtask

    // upper data bits carry junk, the block keeps only the register width
    task automatic apply_config(input logic [slt_pkg::VOFF_W-1:0] voff,
                                input logic [slt_pkg::HGT_W-1:0] hgt,
                                input logic pol,
                                input logic [slt_pkg::LONG_W-1:0] long_t);
        drain();
        cfg_write(slt_pkg::CFG_V_OFFSET, {6'($urandom), voff});
        cfg_write(slt_pkg::CFG_OSD_HEIGHT, {9'($urandom), hgt});
        cfg_write(slt_pkg::CFG_SYNC_POL, {15'($urandom), pol});
        cfg_write(slt_pkg::CFG_LONG_SYNC, long_t);
        i_cfg_wr_en <= 1'b0;
    endtask

    // reset values: zero height, active-low sync, 720-tick threshold
    task automatic test_reset_defaults();
        sync_pulse(100);   // zero height: box ends as the frame starts
        sync_pulse(50);    // short pulse after end of box is ignored
        sync_pulse(721);   // just over threshold: blanking
        sync_pulse(720);   // at threshold still counts as short
        send_item(slt_pkg::EV_VSYNC, 1'b1, $urandom());
    endtask

    task automatic test_box_lines();
        apply_config(10'd2, 7'd2, 1'b1, 16'd100);
        send_item(slt_pkg::EV_VSYNC, 1'b0, $urandom());
        sync_pulse(30);    // frame start
        sync_pulse(30);    // first box line, trailing edge ignored
        lead_edge();
        lead_edge();       // box ended
    endtask

    task automatic test_width_corners();
        apply_config(10'd0, 7'd3, 1'b0, 16'd1);
        send_item(slt_pkg::EV_VSYNC, 1'b1, $urandom());
        // pulse across the timestamp wrap is long
        send_item(slt_pkg::EV_SYNC_EDGE, 1'b0, 32'hFFFF_FFF0);
        send_item(slt_pkg::EV_SYNC_EDGE, 1'b1, 32'h0000_0010);
        // trailing edge stamped before the leading one: negative, so short
        send_item(slt_pkg::EV_SYNC_EDGE, 1'b0, 32'h8000_0000);
        send_item(slt_pkg::EV_SYNC_EDGE, 1'b1, 32'h7FFF_FF00);
        lead_edge();
        lead_edge();
    endtask

    task automatic test_register_extremes();
        apply_config(10'd1023, 7'd127, 1'b1, 16'hFFFF);
        sync_pulse(32'd65536);
        sync_pulse(32'd65535);
        lead_edge();
        lead_edge();
        // rewrite mid-frame; the count carries on under the new box
        apply_config(10'd0, 7'd64, 1'b0, 16'd0);
        lead_edge();
        lead_edge();
        send_item(slt_pkg::EV_VSYNC, 1'b0, $urandom());
        sync_pulse(0);
    endtask

    // output held off for a long stretch while requests keep coming
    task automatic test_output_hold();
        apply_config(10'd1, 7'd20, 1'b1, 16'd500);
        hold_req = 1'b1;
        send_item(slt_pkg::EV_VSYNC, 1'b1, $urandom());
        sync_pulse(40);
        repeat (24) lead_edge();
    endtask

    task automatic test_random_frames();
        int                         lines;
        int                         pick;
        logic [slt_pkg::VOFF_W-1:0] voff;
        logic [slt_pkg::HGT_W-1:0]  hgt;
        logic [slt_pkg::LONG_W-1:0] long_t;
        while (n_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)      voff = 10'($urandom_range(0, 12));
            else if (pick < 95) voff = 10'($urandom_range(13, 120));
            else                voff = 10'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 55)      hgt = 7'($urandom_range(1, 12));
            else if (pick < 70) hgt = '0;
            else if (pick < 85) hgt = 7'($urandom_range(64, 127));
            else                hgt = 7'($urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 70)      long_t = 16'($urandom_range(50, 2000));
            else if (pick < 80) long_t = '0;
            else if (pick < 90) long_t = 16'd1;
            else if (pick < 95) long_t = 16'hFFFF;
            else                long_t = 16'($urandom);
            apply_config(voff, hgt, 1'($urandom_range(0, 1)), long_t);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 1))
                    send_item(slt_pkg::EV_VSYNC, 1'($urandom_range(0, 1)), $urandom());
                else
                    sync_pulse(cfg_long + $urandom_range(1, 3000));
                sync_pulse($urandom_range(0, cfg_long));
                lines = cfg_voff + clamped_height() + $urandom_range(0, 3);
                if (lines > 150)
                    lines = $urandom_range(5, 40);
                repeat (lines) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)       noise_item();
                    else if (pick < 55) lead_edge();
                    else                sync_pulse($urandom_range(0, 3000));
                end
                if ($urandom_range(0, 3) == 0)
                    sync_pulse($urandom_range(0, cfg_long));
            end
        end
    endtask

    // result side stall pattern, plus the long hold-off on request
    initial begin : rx_side
        t_rx_mode mode;
        int       mode_left;
        mode = RX_FLOW;
        mode_left = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_FLOW:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:  i_stall <= ~i_stall;
                endcase
            end
        end
    end

    initial begin : report_check
        t_line_report want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result action=%0d first=%0d line=%0d",
                             $time, o_action, o_first_line, o_box_line);
                    errors++;
                end else begin
                    want = pending_reports.pop_front();
                    if (o_action !== want.action || o_first_line !== want.first_line ||
                        o_box_line !== want.box_line) begin
                        $display({"%0t: expected action=%0d first=%0d line=%0d,",
                                  " got action=%0d first=%0d line=%0d"},
                                 $time, want.action, want.first_line, want.box_line,
                                 o_action, o_first_line, o_box_line);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_event_kind = slt_pkg::EV_SYNC_EDGE;
        i_pin_level  = 1'b0;
        i_timestamp  = '0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = slt_pkg::CFG_V_OFFSET;
        i_cfg_data   = '0;
        burst_left   = $urandom_range(1, 40);
        now_ts       = $urandom();
        trk_pos      = slt_pkg::POS_BLANK;
        trk_pulse_t0 = '0;
        cfg_voff     = slt_pkg::V_OFFSET_RST;
        cfg_height   = slt_pkg::OSD_HEIGHT_RST;
        cfg_pol      = slt_pkg::SYNC_POL_RST;
        cfg_long     = slt_pkg::LONG_SYNC_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_box_lines();
        test_width_corners();
        test_register_extremes();
        test_output_hold();
        test_random_frames();
        drain();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
